/* rtl/core/ecg_shr_pkg.sv */
package ecg_shr_pkg;

  // Fixed field widths
  localparam int unsigned SampleFieldW = 16;
  localparam int unsigned RateW        = 16;
  localparam int unsigned CntW         = 16;
  localparam int unsigned BoundW       = 18;
  localparam int unsigned CfgAddrW     = 3;
  localparam int unsigned CfgDataW     = 18;

  // Number of items that only fill the sample history
  localparam logic [2:0] FillLen = 3'd5;

  // Register defaults after reset
  localparam logic [BoundW-1:0] SlopeLowRst     = 18'd100;
  localparam logic [BoundW-1:0] SlopeHighRst    = 18'd1000;
  localparam logic [CntW-1:0]   MinGapRst       = 16'd60;
  localparam logic [CntW-1:0]   TimeoutRst      = 16'd1000;
  localparam logic [CntW-1:0]   RateNumRst      = 16'd30000;

  // Configuration register indexes
  typedef enum logic [CfgAddrW-1:0] {
    CfgSlopeLow  = 3'd0,
    CfgSlopeHigh = 3'd1,
    CfgMinGap    = 3'd2,
    CfgTimeout   = 3'd3,
    CfgRateNum   = 3'd4
  } cfg_idx_e;

  // Operation of the shared adder
  typedef enum logic {
    AluAdd = 1'b0,
    AluSub = 1'b1
  } alu_op_e;

  // Sequencer states
  typedef enum logic [11:0] {
    StIdle     = 12'b0000_0000_0001,
    StSlope0   = 12'b0000_0000_0010,
    StSlope1   = 12'b0000_0000_0100,
    StSlope2   = 12'b0000_0000_1000,
    StCmpLow   = 12'b0000_0001_0000,
    StCmpHigh  = 12'b0000_0010_0000,
    StTimeout  = 12'b0000_0100_0000,
    StGap      = 12'b0000_1000_0000,
    StGapCmp   = 12'b0001_0000_0000,
    StInterval = 12'b0010_0000_0000,
    StDivide   = 12'b0100_0000_0000,
    StDone     = 12'b1000_0000_0000
  } state_e;

endpackage

/* rtl/core/ecg_shr_alu.sv */
module ecg_shr_alu #(
  parameter int unsigned Width = 20
) (
  input  logic [Width-1:0]      a_i,
  input  logic [Width-1:0]      b_i,
  input  ecg_shr_pkg::alu_op_e  op_i,
  output logic [Width-1:0]      res_o
);

  logic [Width-1:0] b_eff;

  // Two's complement add; subtraction inverts b and adds the carry in.
  always_comb begin
    b_eff = (op_i == ecg_shr_pkg::AluSub) ? ~b_i : b_i;
    res_o = a_i + b_eff + Width'(op_i == ecg_shr_pkg::AluSub);
  end

endmodule

/* rtl/core/ecg_slope_heart_rate.sv */
// Channel    | Direction | Payload
// -----------+-----------+-------------------------------------------
// s_axis     | in        | tdata[15:0] = sample (two's complement)
// m_axis     | out       | tdata[15:0] = beat_rate (unsigned bpm)
// cfg        | in        | write enable, register index, write data
//
// One item at a time; slopes, bound compares and the divide share one adder.
// The first five items only fill the history; later ones compute the slope and compare it,
// and an item that computes a new rate runs the 16 divider steps on the adder.
// Reset clears history, counters and rate and loads the register defaults.
// A result waits in the output register while the next item is taken; the
// sequencer stalls in its last state only when that register is still full.
module ecg_slope_heart_rate #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // Input samples
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [ecg_shr_pkg::SampleFieldW-1:0]  s_axis_tdata,  // [15:0] sample
  // Heart rate results
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [ecg_shr_pkg::RateW-1:0]         m_axis_tdata,  // [15:0] beat_rate
  // Configuration writes
  input  logic                                  cfg_we_i,
  input  logic [ecg_shr_pkg::CfgAddrW-1:0]      cfg_addr_i,
  input  logic [ecg_shr_pkg::CfgDataW-1:0]      cfg_wdata_i
);

  localparam int unsigned SB  = SAMPLE_BITS;
  localparam int unsigned AW  = (SB + 4 > 20) ? SB + 4 : 20;
  localparam int unsigned CW  = ecg_shr_pkg::CntW;
  localparam int unsigned BW  = ecg_shr_pkg::BoundW;
  localparam int unsigned FW  = ecg_shr_pkg::SampleFieldW;

  // Saturating increment of a 16-bit counter
  function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
    sat_inc = (v == '1) ? v : v + CW'(1);
  endfunction

  // Configuration registers
  logic [BW-1:0] slope_low_q, slope_high_q;
  logic [CW-1:0] min_gap_q, timeout_q, rate_num_q;

  // Detector state
  ecg_shr_pkg::state_e state_q, state_d;
  logic [SB-1:0] sample_q;
  logic [SB-1:0] window_q [4];
  logic [2:0]    fill_q;
  logic          first_q, second_q;
  logic [CW-1:0] fpos_q, spos_q, scnt_q, rej_q, rate_q;
  logic [AW-1:0] acc_q;
  logic          lt_low_q, gt_low_q;
  logic [CW-1:0] ivl_q, rem_q, quo_q;
  logic [3:0]    step_q;

  // Output register
  logic          out_valid_q;
  logic [CW-1:0] out_data_q;

  // Shared adder
  logic [AW-1:0]         alu_a, alu_b, alu_res;
  ecg_shr_pkg::alu_op_e  alu_op;
  logic                  alu_neg;

  // Incoming sample cut to SAMPLE_BITS; bits beyond the field are zero
  logic [SB+FW-1:0] smp_ext;
  logic [SB-1:0]    smp_in;
  logic             in_xfer;
  logic [CW:0]      div_shift;
  logic             div_ok;
  logic [CW-1:0]    quo_nx;

  assign smp_ext = {{SB{1'b0}}, s_axis_tdata};
  assign smp_in  = smp_ext[SB-1:0];

  assign s_axis_tready = (state_q == ecg_shr_pkg::StIdle);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  assign alu_neg   = alu_res[AW-1];
  assign div_shift = {rem_q, quo_q[CW-1]};
  assign div_ok    = !alu_neg;
  assign quo_nx    = {quo_q[CW-2:0], div_ok};

  // Operand selection for the shared adder
  always_comb begin
    alu_a  = '0;
    alu_b  = '0;
    alu_op = ecg_shr_pkg::AluAdd;
    unique case (state_q)
      ecg_shr_pkg::StSlope0: begin
        alu_a  = {{(AW-SB-1){sample_q[SB-1]}}, sample_q, 1'b0};
        alu_b  = {{(AW-SB-1){window_q[0][SB-1]}}, window_q[0], 1'b0};
        alu_op = ecg_shr_pkg::AluSub;
      end
      ecg_shr_pkg::StSlope1: begin
        alu_a  = acc_q;
        alu_b  = {{(AW-SB){window_q[3][SB-1]}}, window_q[3]};
      end
      ecg_shr_pkg::StSlope2: begin
        alu_a  = acc_q;
        alu_b  = {{(AW-SB){window_q[1][SB-1]}}, window_q[1]};
        alu_op = ecg_shr_pkg::AluSub;
      end
      ecg_shr_pkg::StCmpLow: begin
        alu_a  = acc_q;
        alu_b  = {{(AW-BW){1'b0}}, slope_low_q};
        alu_op = ecg_shr_pkg::AluSub;
      end
      ecg_shr_pkg::StCmpHigh: begin
        alu_a  = {{(AW-BW){1'b0}}, slope_high_q};
        alu_b  = acc_q;
        alu_op = ecg_shr_pkg::AluSub;
      end
      ecg_shr_pkg::StTimeout: begin
        alu_a  = {{(AW-CW){1'b0}}, timeout_q};
        alu_b  = {{(AW-CW){1'b0}}, rej_q};
        alu_op = ecg_shr_pkg::AluSub;
      end
      ecg_shr_pkg::StGap, ecg_shr_pkg::StInterval: begin
        alu_a  = {{(AW-CW){1'b0}}, spos_q};
        alu_b  = {{(AW-CW){1'b0}}, fpos_q};
        alu_op = ecg_shr_pkg::AluSub;
      end
      ecg_shr_pkg::StGapCmp: begin
        alu_a  = {{(AW-CW){1'b0}}, ivl_q};
        alu_b  = {{(AW-CW){1'b0}}, min_gap_q};
        alu_op = ecg_shr_pkg::AluSub;
      end
      ecg_shr_pkg::StDivide: begin
        alu_a  = {{(AW-CW-1){1'b0}}, div_shift};
        alu_b  = {{(AW-CW){1'b0}}, ivl_q};
        alu_op = ecg_shr_pkg::AluSub;
      end
      default: begin
        alu_a  = '0;
        alu_b  = '0;
        alu_op = ecg_shr_pkg::AluAdd;
      end
    endcase
  end

  ecg_shr_alu #(
    .Width (AW)
  ) u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .op_i  (alu_op),
    .res_o (alu_res)
  );

  // Configuration register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slope_low_q  <= ecg_shr_pkg::SlopeLowRst;
      slope_high_q <= ecg_shr_pkg::SlopeHighRst;
      min_gap_q    <= ecg_shr_pkg::MinGapRst;
      timeout_q    <= ecg_shr_pkg::TimeoutRst;
      rate_num_q   <= ecg_shr_pkg::RateNumRst;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        ecg_shr_pkg::CfgSlopeLow:  slope_low_q  <= cfg_wdata_i;
        ecg_shr_pkg::CfgSlopeHigh: slope_high_q <= cfg_wdata_i;
        ecg_shr_pkg::CfgMinGap:    min_gap_q    <= cfg_wdata_i[CW-1:0];
        ecg_shr_pkg::CfgTimeout:   timeout_q    <= cfg_wdata_i[CW-1:0];
        ecg_shr_pkg::CfgRateNum:   rate_num_q   <= cfg_wdata_i[CW-1:0];
        default: ;
      endcase
    end
  end

  // Next state of the sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ecg_shr_pkg::StIdle: begin
        if (in_xfer) begin
          state_d = (fill_q < ecg_shr_pkg::FillLen) ? ecg_shr_pkg::StDone
                                                     : ecg_shr_pkg::StSlope0;
        end
      end
      ecg_shr_pkg::StSlope0:  state_d = ecg_shr_pkg::StSlope1;
      ecg_shr_pkg::StSlope1:  state_d = ecg_shr_pkg::StSlope2;
      ecg_shr_pkg::StSlope2:  state_d = ecg_shr_pkg::StCmpLow;
      ecg_shr_pkg::StCmpLow:  state_d = ecg_shr_pkg::StCmpHigh;
      ecg_shr_pkg::StCmpHigh: begin
        priority if (lt_low_q || alu_neg) begin
          state_d = ecg_shr_pkg::StTimeout;
        end else if (first_q && second_q) begin
          state_d = ecg_shr_pkg::StInterval;
        end else if (gt_low_q && first_q) begin
          state_d = ecg_shr_pkg::StGap;
        end else begin
          state_d = ecg_shr_pkg::StDone;
        end
      end
      ecg_shr_pkg::StTimeout: state_d = ecg_shr_pkg::StDone;
      ecg_shr_pkg::StGap:     state_d = ecg_shr_pkg::StGapCmp;
      ecg_shr_pkg::StGapCmp:  state_d = ecg_shr_pkg::StDone;
      ecg_shr_pkg::StInterval: begin
        state_d = (alu_res[CW-1:0] == '0) ? ecg_shr_pkg::StDone : ecg_shr_pkg::StDivide;
      end
      ecg_shr_pkg::StDivide: begin
        if (step_q == '1) begin
          state_d = ecg_shr_pkg::StDone;
        end
      end
      ecg_shr_pkg::StDone: begin
        if (!out_valid_q || m_axis_tready) begin
          state_d = ecg_shr_pkg::StIdle;
        end
      end
      default: state_d = ecg_shr_pkg::StIdle;
    endcase
  end

  // Control state and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ecg_shr_pkg::StIdle;
      window_q    <= '{default: '0};
      fill_q      <= '0;
      first_q     <= 1'b0;
      second_q    <= 1'b0;
      fpos_q      <= '0;
      spos_q      <= '0;
      scnt_q      <= '0;
      rej_q       <= '0;
      rate_q      <= '0;
      out_valid_q <= 1'b0;
      step_q      <= '0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        ecg_shr_pkg::StIdle: begin
          // History fill: shift the sample in at once
          if (in_xfer && (fill_q < ecg_shr_pkg::FillLen)) begin
            window_q[0] <= window_q[1];
            window_q[1] <= window_q[2];
            window_q[2] <= window_q[3];
            window_q[3] <= smp_in;
            fill_q      <= fill_q + 3'd1;
          end
        end
        ecg_shr_pkg::StSlope2: begin
          // Last window read happens here; shift afterwards
          window_q[0] <= window_q[1];
          window_q[1] <= window_q[2];
          window_q[2] <= window_q[3];
          window_q[3] <= sample_q;
        end
        ecg_shr_pkg::StCmpHigh: begin
          if (lt_low_q || alu_neg) begin
            scnt_q <= sat_inc(scnt_q);
            rej_q  <= sat_inc(rej_q);
          end else begin
            rej_q <= '0;
            if (first_q && second_q) begin
              first_q  <= 1'b0;
              second_q <= 1'b0;
              scnt_q   <= '0;
            end else begin
              if (gt_low_q) begin
                if (!first_q) begin
                  first_q <= 1'b1;
                  fpos_q  <= scnt_q;
                end else begin
                  spos_q <= scnt_q;
                end
              end
              scnt_q <= sat_inc(scnt_q);
            end
          end
        end
        ecg_shr_pkg::StTimeout: begin
          // Reject count beyond the limit clears the rate
          if (alu_neg) begin
            rate_q <= '0;
          end
        end
        ecg_shr_pkg::StGapCmp: begin
          second_q <= !alu_neg;
        end
        ecg_shr_pkg::StInterval: begin
          step_q <= '0;
          if (alu_res[CW-1:0] == '0) begin
            rate_q <= '1;
          end
        end
        ecg_shr_pkg::StDivide: begin
          step_q <= step_q + 4'd1;
          if (step_q == '1) begin
            rate_q <= quo_nx;
          end
        end
        ecg_shr_pkg::StDone: begin
          if (!out_valid_q || m_axis_tready) begin
            out_valid_q <= 1'b1;
          end
        end
        default: ;
      endcase
      // Drop the result once it is taken and nothing replaces it
      if (out_valid_q && m_axis_tready &&
          !(state_q == ecg_shr_pkg::StDone)) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      sample_q <= smp_in;
    end
    unique case (state_q)
      ecg_shr_pkg::StSlope0, ecg_shr_pkg::StSlope1, ecg_shr_pkg::StSlope2: begin
        acc_q <= alu_res;
      end
      ecg_shr_pkg::StCmpLow: begin
        lt_low_q <= alu_neg;
        gt_low_q <= !alu_neg && (alu_res != '0);
      end
      ecg_shr_pkg::StGap: begin
        ivl_q <= alu_res[CW-1:0];
      end
      ecg_shr_pkg::StInterval: begin
        ivl_q <= alu_res[CW-1:0];
        rem_q <= '0;
        quo_q <= rate_num_q;
      end
      ecg_shr_pkg::StDivide: begin
        // Restoring divider step: keep the difference when it is not negative
        rem_q <= div_ok ? alu_res[CW-1:0] : div_shift[CW-1:0];
        quo_q <= quo_nx;
      end
      ecg_shr_pkg::StDone: begin
        if (!out_valid_q || m_axis_tready) begin
          out_data_q <= rate_q;
        end
      end
      default: ;
    endcase
  end

endmodule
